// ===== src/ipsr_pkg.sv =====
package ipsr_pkg;

    localparam int SEC_BITS       = 32;
    localparam int USEC_BITS      = 20;
    localparam int LIMIT_BITS     = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SENSE_ACTIVE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_MERGE_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_SPACE_LIMIT  = 2'd2;

    localparam logic                  SENSE_RESET       = 1'b1;
    localparam logic [LIMIT_BITS-1:0] MERGE_LIMIT_RESET = 24'd250;
    localparam logic [LIMIT_BITS-1:0] LONG_SPACE_RESET  = 24'd20000;

    localparam int LONG_GAP_SEC = 15;
    localparam int USEC_PER_SEC = 1000000;

    // Wide enough for fifteen seconds plus any 20-bit microsecond value, signed.
    localparam int SPAN_BITS = 26;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] merge_limit;
        logic [LIMIT_BITS-1:0] long_limit;
    } limits_t;

    typedef struct packed {
        logic load;
        logic value;
    } pol_load_t;

endpackage

// ===== src/ipsr_if.sv =====
interface ipsr_edge_if;
    logic                           valid;
    logic                           ready;
    logic [ipsr_pkg::SEC_BITS-1:0]  time_sec;
    logic [ipsr_pkg::USEC_BITS-1:0] time_usec;
    logic                           level;

    modport source (output valid, time_sec, time_usec, level, input ready);
    modport sink (input valid, time_sec, time_usec, level, output ready);
endinterface

interface ipsr_word_if #(parameter int DURATION_BITS = 24);
    logic                     valid;
    logic                     ready;
    logic [DURATION_BITS-1:0] duration;
    logic                     is_pulse;
    logic                     last_of_run;

    modport source (output valid, duration, is_pulse, last_of_run, input ready);
    modport sink (input valid, duration, is_pulse, last_of_run, output ready);
endinterface

interface ipsr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ipsr_pkg::CFG_INDEX_BITS-1:0] index;
    logic [ipsr_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ipsr_front.sv =====
module ipsr_front #(
    parameter int DURATION_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    ipsr_edge_if.sink                 ir_in,
    input  ipsr_pkg::pol_load_t       pol_cfg,
    output logic                      wr_en,
    output logic [DURATION_BITS:0]    wr_data,
    input  logic                      full
);

    localparam int                       DIFF_BITS = ipsr_pkg::SEC_BITS + 1;
    localparam int                       SPAN_BITS = ipsr_pkg::SPAN_BITS;
    localparam logic [DURATION_BITS-1:0] DMAX      = '1;

    logic [ipsr_pkg::SEC_BITS-1:0]  last_sec_reg;
    logic [ipsr_pkg::USEC_BITS-1:0] last_usec_reg;
    logic                           polarity_reg;
    logic                           polarity_next;

    logic [DIFF_BITS-1:0]     sec_diff;
    logic                     backwards;
    logic                     long_gap;
    logic                     pulse;
    logic [SPAN_BITS-1:0]     scaled;
    logic [SPAN_BITS-1:0]     span;
    logic [DURATION_BITS-1:0] dur;
    logic                     accept;

    always_comb
    begin
        sec_diff  = {1'b0, ir_in.time_sec} - {1'b0, last_sec_reg};
        backwards = (ir_in.time_sec < last_sec_reg) ||
                    ((ir_in.time_sec == last_sec_reg) && (ir_in.time_usec < last_usec_reg));
        long_gap  = !backwards && (sec_diff > DIFF_BITS'(ipsr_pkg::LONG_GAP_SEC));

        // A long gap on a level that reads as a pulse turns the polarity around.
        polarity_next = polarity_reg;
        if (long_gap && (ir_in.level == polarity_reg))
        begin
            polarity_next = ~polarity_reg;
        end
        pulse = (ir_in.level == polarity_next);

        scaled = SPAN_BITS'(sec_diff[3:0]) * SPAN_BITS'(ipsr_pkg::USEC_PER_SEC);
        span   = scaled + SPAN_BITS'(ir_in.time_usec) - SPAN_BITS'(last_usec_reg);

        if (backwards || long_gap)
        begin
            dur = DMAX;
        end
        else if (span[SPAN_BITS-1])
        begin
            dur = '0;
        end
        else if (32'(span[SPAN_BITS-2:0]) > 32'(DMAX))
        begin
            dur = DMAX;
        end
        else
        begin
            dur = DURATION_BITS'(span[SPAN_BITS-2:0]);
        end
    end

    assign accept      = ir_in.valid && !full;
    assign ir_in.ready = !full;
    assign wr_en       = accept;
    assign wr_data     = {dur, pulse};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sec_reg  <= '0;
            last_usec_reg <= '0;
            polarity_reg  <= ipsr_pkg::SENSE_RESET;
        end
        else
        begin
            if (pol_cfg.load)
            begin
                polarity_reg <= pol_cfg.value;
            end
            else if (accept)
            begin
                polarity_reg <= polarity_next;
            end
            if (accept)
            begin
                last_sec_reg  <= ir_in.time_sec;
                last_usec_reg <= ir_in.time_usec;
            end
        end
    end

endmodule

// ===== src/ipsr_fifo.sv =====
module ipsr_fifo #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_BITS'(DEPTH))
        else $error("queue count beyond its depth");

    assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && empty) && !(wr_en && full))
        else $error("queue read while empty or written while full");

endmodule

// ===== src/ipsr_back.sv =====
module ipsr_back #(
    parameter int DURATION_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ipsr_pkg::limits_t       limits,
    input  logic                    q_empty,
    input  logic [DURATION_BITS:0]  q_data,
    output logic                    q_rd,
    ipsr_word_if.source             word_out
);

    localparam int SLOTS     = 3;
    localparam int SCNT_BITS = $clog2(SLOTS + 1);

    logic [DURATION_BITS-1:0] dur_reg [SLOTS];
    logic [DURATION_BITS-1:0] dur_next [SLOTS];
    logic                     pls_reg [SLOTS];
    logic                     pls_next [SLOTS];
    logic                     lst_reg [SLOTS];
    logic                     lst_next [SLOTS];
    logic [SCNT_BITS-1:0]     cnt_reg;
    logic [SCNT_BITS-1:0]     cnt_next;

    logic                     holding_reg;
    logic                     holding_next;
    logic [DURATION_BITS-1:0] held_reg;
    logic [DURATION_BITS-1:0] held_next;
    logic [DURATION_BITS-1:0] pulse_sum_reg;
    logic [DURATION_BITS-1:0] pulse_sum_next;

    logic                     take;
    logic [DURATION_BITS-1:0] dur;
    logic                     pulse;
    logic [DURATION_BITS-1:0] sum_add;
    logic [DURATION_BITS-1:0] fold_sum;
    logic [DURATION_BITS-1:0] fold_all;
    logic                     dur_long;
    logic                     sum_over;

    function automatic logic [DURATION_BITS-1:0] sat_add(
        input logic [DURATION_BITS-1:0] a,
        input logic [DURATION_BITS-1:0] b
    );
        logic [DURATION_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DURATION_BITS] ? '1 : s[DURATION_BITS-1:0];
    endfunction

    always_comb
    begin
        take  = word_out.valid && word_out.ready;
        q_rd  = !q_empty && ((cnt_reg == '0) ||
                             ((cnt_reg == SCNT_BITS'(1)) && word_out.ready));
        dur   = q_data[DURATION_BITS:1];
        pulse = q_data[0];

        sum_add  = sat_add(pulse_sum_reg, dur);
        fold_sum = sat_add(held_reg, pulse_sum_reg);
        fold_all = sat_add(fold_sum, dur);
        dur_long = 32'(dur) > 32'(limits.long_limit);
        sum_over = 32'(sum_add) > 32'(limits.merge_limit);

        dur_next       = dur_reg;
        pls_next       = pls_reg;
        lst_next       = lst_reg;
        cnt_next       = cnt_reg;
        holding_next   = holding_reg;
        held_next      = held_reg;
        pulse_sum_next = pulse_sum_reg;

        if (take)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                dur_next[i] = dur_reg[i+1];
                pls_next[i] = pls_reg[i+1];
                lst_next[i] = lst_reg[i+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end

        if (q_rd)
        begin
            if (holding_reg && pulse)
            begin
                if (sum_over)
                begin
                    dur_next[0] = held_reg;
                    pls_next[0] = 1'b0;
                    lst_next[0] = 1'b0;
                    dur_next[1] = sum_add;
                    pls_next[1] = 1'b1;
                    lst_next[1] = 1'b1;
                    cnt_next       = SCNT_BITS'(2);
                    holding_next   = 1'b0;
                    pulse_sum_next = '0;
                end
                else
                begin
                    pulse_sum_next = sum_add;
                end
            end
            else if (!pulse && !holding_reg && dur_long)
            begin
                held_next    = dur;
                holding_next = 1'b1;
            end
            else if (!pulse && holding_reg && dur_long)
            begin
                held_next      = fold_all;
                pulse_sum_next = '0;
            end
            else if (!pulse && holding_reg)
            begin
                dur_next[0] = held_reg;
                pls_next[0] = 1'b0;
                lst_next[0] = 1'b0;
                dur_next[1] = pulse_sum_reg;
                pls_next[1] = 1'b1;
                lst_next[1] = 1'b0;
                dur_next[2] = dur;
                pls_next[2] = 1'b0;
                lst_next[2] = 1'b1;
                cnt_next       = SCNT_BITS'(3);
                holding_next   = 1'b0;
                pulse_sum_next = '0;
            end
            else
            begin
                dur_next[0] = dur;
                pls_next[0] = pulse;
                lst_next[0] = 1'b1;
                cnt_next    = SCNT_BITS'(1);
            end
        end
    end

    assign word_out.valid       = (cnt_reg != '0);
    assign word_out.duration    = dur_reg[0];
    assign word_out.is_pulse    = pls_reg[0];
    assign word_out.last_of_run = lst_reg[0];

    always_ff @(posedge clk)
    begin
        dur_reg <= dur_next;
        pls_reg <= pls_next;
        lst_reg <= lst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            holding_reg   <= 1'b0;
            held_reg      <= '0;
            pulse_sum_reg <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            holding_reg   <= holding_next;
            held_reg      <= held_next;
            pulse_sum_reg <= pulse_sum_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !holding_reg |-> (pulse_sum_reg == '0))
        else $error("pulse sum kept outside a hold");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == SCNT_BITS'(1)) |-> lst_reg[0])
        else $error("single pending word not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == SCNT_BITS'(3)) |-> (!lst_reg[0] && !lst_reg[1] && lst_reg[2]))
        else $error("three pending words with wrong last marks");

endmodule

// ===== src/ir_pulse_space_recorder_unit.sv =====
// Infrared pulse/space recorder.
// The ir_in channel takes one receiver edge per request: a timestamp in seconds and
// microseconds and the line level. The word_out channel delivers zero to three
// words per edge, each a duration in microseconds tagged pulse or space, with
// last_of_run set on the final word of an edge. The cfg channel writes the
// polarity (which also reloads the live polarity) and the two filter limits; it
// is always ready and is meant to be written while the block is idle.
// The front stage measures and classifies an edge in the cycle it is accepted and
// pushes it into a queue of QUEUE_DEPTH entries. The back stage pops one entry and
// loads its words into a three-word output buffer.
// The first word of an edge is registered in the queue, then in the output buffer.
// Edges are accepted one per cycle while the queue has room; the sustained rate
// is set by the output port, which moves one word per cycle while word_out is
// ready, so an edge with three words keeps the next one waiting until its last
// word is taken. When word_out stalls, words wait in the buffer, the queue fills,
// then ir_in.ready drops. Reset clears the timestamp, the hold, queue and buffer,
// reads a high level as a pulse and sets the limits to 250 and 20000 microseconds.
module ir_pulse_space_recorder_unit #(
    parameter int DURATION_BITS = 24,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    ipsr_edge_if.sink   ir_in,
    ipsr_word_if.source word_out,
    ipsr_cfg_if.sink    cfg
);

    logic [ipsr_pkg::LIMIT_BITS-1:0] merge_limit_reg;
    logic [ipsr_pkg::LIMIT_BITS-1:0] long_limit_reg;
    ipsr_pkg::limits_t               limits;
    ipsr_pkg::pol_load_t             pol_cfg;

    logic                   q_wr;
    logic [DURATION_BITS:0] q_wr_data;
    logic                   q_full;
    logic                   q_rd;
    logic [DURATION_BITS:0] q_rd_data;
    logic                   q_empty;

    assign cfg.ready          = 1'b1;
    assign pol_cfg.load       = cfg.valid && (cfg.index == ipsr_pkg::CFG_SENSE_ACTIVE_LOW);
    assign pol_cfg.value      = cfg.data[0];
    assign limits.merge_limit = merge_limit_reg;
    assign limits.long_limit  = long_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_limit_reg <= ipsr_pkg::MERGE_LIMIT_RESET;
            long_limit_reg  <= ipsr_pkg::LONG_SPACE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ipsr_pkg::CFG_PULSE_MERGE_LIMIT:
                begin
                    merge_limit_reg <= cfg.data[ipsr_pkg::LIMIT_BITS-1:0];
                end
                ipsr_pkg::CFG_LONG_SPACE_LIMIT:
                begin
                    long_limit_reg <= cfg.data[ipsr_pkg::LIMIT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    ipsr_front #(
        .DURATION_BITS(DURATION_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ir_in   (ir_in),
        .pol_cfg (pol_cfg),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full)
    );

    ipsr_fifo #(
        .WIDTH(DURATION_BITS + 1),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    ipsr_back #(
        .DURATION_BITS(DURATION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .limits   (limits),
        .q_empty  (q_empty),
        .q_data   (q_rd_data),
        .q_rd     (q_rd),
        .word_out (word_out)
    );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ipsr_pkg::*;

    localparam int DUR_BITS     = 24;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 3000;

    localparam logic [DUR_BITS-1:0]       DUR_MAX   = '1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [DUR_BITS-1:0] duration;
        logic                is_pulse;
        logic                last_of_run;
    } ir_word_t;

    // Tracks edge timing, polarity and the noise filter hold, and keeps the words that
    // the block still owes.
    class ir_word_predictor;
        logic                  sense;
        logic [LIMIT_BITS-1:0] merge_limit;
        logic [LIMIT_BITS-1:0] long_limit;
        logic [SEC_BITS-1:0]   prev_sec;
        logic [USEC_BITS-1:0]  prev_usec;
        logic                  polarity;
        logic [DUR_BITS-1:0]   held_space;
        logic [DUR_BITS-1:0]   pulse_sum;
        logic                  holding;
        ir_word_t              pending_words[$];
        int                    errors;

        function new();
            sense       = SENSE_RESET;
            merge_limit = MERGE_LIMIT_RESET;
            long_limit  = LONG_SPACE_RESET;
            prev_sec    = '0;
            prev_usec   = '0;
            polarity    = SENSE_RESET;
            held_space  = '0;
            pulse_sum   = '0;
            holding     = 1'b0;
            errors      = 0;
        endfunction

        function logic [DUR_BITS-1:0] sat_sum(logic [DUR_BITS-1:0] a, logic [DUR_BITS-1:0] b);
            logic [DUR_BITS:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[DUR_BITS] ? DUR_MAX : s[DUR_BITS-1:0];
        endfunction

        function void push_word(logic [DUR_BITS-1:0] dur, logic pls);
            pending_words.push_back('{duration: dur, is_pulse: pls, last_of_run: 1'b0});
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_SENSE_ACTIVE_LOW:
                begin
                    sense    = data[0];
                    polarity = data[0];
                end
                CFG_PULSE_MERGE_LIMIT: merge_limit = data[LIMIT_BITS-1:0];
                CFG_LONG_SPACE_LIMIT:  long_limit  = data[LIMIT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void take_edge(logic [SEC_BITS-1:0] sec, logic [USEC_BITS-1:0] usec, logic lvl);
            logic [DUR_BITS-1:0] d;
            longint              span;
            logic                pulse;
            int                  n_before;
            n_before = pending_words.size();
            if (sec < prev_sec || (sec == prev_sec && usec < prev_usec))
            begin
                d = DUR_MAX;
            end
            else if ((sec - prev_sec) > LONG_GAP_SEC)
            begin
                d = DUR_MAX;
                if (lvl == polarity)
                    polarity = !polarity;
            end
            else
            begin
                span = longint'(sec - prev_sec) * USEC_PER_SEC + longint'(usec)
                       - longint'(prev_usec);
                if (span < 0)
                    span = 0;
                if (span > longint'(DUR_MAX))
                    span = longint'(DUR_MAX);
                d = span[DUR_BITS-1:0];
            end
            pulse     = (lvl == polarity);
            prev_sec  = sec;
            prev_usec = usec;

            if (holding && pulse)
            begin
                pulse_sum = sat_sum(pulse_sum, d);
                if (pulse_sum > merge_limit)
                begin
                    push_word(held_space, 1'b0);
                    push_word(pulse_sum, 1'b1);
                    holding   = 1'b0;
                    pulse_sum = '0;
                end
            end
            else if (!pulse && !holding && d > long_limit)
            begin
                held_space = d;
                holding    = 1'b1;
            end
            else if (!pulse && holding && d > long_limit)
            begin
                held_space = sat_sum(sat_sum(held_space, pulse_sum), d);
                pulse_sum  = '0;
            end
            else
            begin
                if (!pulse && holding)
                begin
                    push_word(held_space, 1'b0);
                    push_word(pulse_sum, 1'b1);
                    holding   = 1'b0;
                    pulse_sum = '0;
                end
                push_word(d, pulse);
            end

            if (pending_words.size() > n_before)
                pending_words[pending_words.size()-1].last_of_run = 1'b1;
        endfunction

        function void compare_word(ir_word_t got);
            ir_word_t want;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word duration %0d is_pulse %0b last_of_run %0b",
                         $time, got.duration, got.is_pulse, got.last_of_run);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got.duration !== want.duration)
            begin
                $display("%0t: duration expected %0d, got %0d", $time, want.duration,
                         got.duration);
                errors++;
            end
            if (got.is_pulse !== want.is_pulse)
            begin
                $display("%0t: is_pulse expected %0b, got %0b", $time, want.is_pulse,
                         got.is_pulse);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $display("%0t: last_of_run expected %0b, got %0b", $time, want.last_of_run,
                         got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ipsr_edge_if                             edge_ch();
    ipsr_word_if #(.DURATION_BITS(DUR_BITS)) word_ch();
    ipsr_cfg_if                              cfg_ch();

    ir_pulse_space_recorder_unit #(
        .DURATION_BITS(DUR_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ir_in   (edge_ch),
        .word_out(word_ch),
        .cfg     (cfg_ch)
    );

    ir_word_predictor     ir_words = new();
    logic [SEC_BITS-1:0]  tx_sec;
    logic [USEC_BITS-1:0] tx_usec;
    int                   burst_left;
    int                   idle_cycles = 0;
    bit                   hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (edge_ch.valid && edge_ch.ready)
            ir_words.take_edge(edge_ch.time_sec, edge_ch.time_usec, edge_ch.level);
        if (word_ch.valid && word_ch.ready)
            ir_words.compare_word({word_ch.duration, word_ch.is_pulse, word_ch.last_of_run});
        if (cfg_ch.valid && cfg_ch.ready)
            ir_words.write_reg(cfg_ch.index, cfg_ch.data);
        if (!rst_n || (edge_ch.valid && edge_ch.ready) || (word_ch.valid && word_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // The word receiver stalls in segments of differing patterns. The first hold-off
    // request from the stimulus makes it refuse words long enough for the edge queue
    // to fill.
    initial
    begin
        int mode;
        int seg_len;
        int k;
        bit held_off;
        held_off      = 1'b0;
        k             = 0;
        word_ch.ready = 1'b0;
        forever
        begin
            if (hold_off_req && !held_off)
            begin
                held_off = 1'b1;
                mode     = 10;
                seg_len  = $urandom_range(80, 140);
            end
            else
            begin
                mode    = $urandom_range(0, 9);
                seg_len = (mode == 9) ? $urandom_range(30, 90) : $urandom_range(5, 60);
            end
            repeat (seg_len)
            begin
                @(negedge clk);
                k++;
                if (mode <= 2)
                    word_ch.ready <= 1'b1;
                else if (mode <= 5)
                    word_ch.ready <= ($urandom_range(0, 3) != 0);
                else if (mode <= 7)
                    word_ch.ready <= (k % 3 != 0);
                else if (mode == 8)
                    word_ch.ready <= ($urandom_range(0, 3) == 0);
                else
                    word_ch.ready <= 1'b0;
            end
        end
    end

    task automatic edge_at(logic [SEC_BITS-1:0] sec, logic [USEC_BITS-1:0] usec, logic lvl);
        int gap;
        tx_sec  = sec;
        tx_usec = usec;
        @(negedge clk);
        edge_ch.valid     <= 1'b1;
        edge_ch.time_sec  <= sec;
        edge_ch.time_usec <= usec;
        edge_ch.level     <= lvl;
        @(posedge clk);
        while (!edge_ch.ready)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap        = $urandom_range(1, 8);
            @(negedge clk);
            edge_ch.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic edge_after(int unsigned delta, logic lvl);
        longint total;
        total = longint'(tx_usec) + delta;
        edge_at(tx_sec + SEC_BITS'(total / USEC_PER_SEC), USEC_BITS'(total % USEC_PER_SEC), lvl);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        edge_ch.valid <= 1'b0;
        while (ir_words.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Mostly plausible receiver traffic: pulses, short and long spaces and pulse bursts
    // near the merge limit, mixed with clock jumps and odd timestamps.
    task automatic random_edge();
        int   r;
        logic pl;
        pl = ir_words.polarity;
        r  = $urandom_range(0, 99);
        if (r < 30)
            edge_after($urandom_range(50, 700), pl);
        else if (r < 55)
            edge_after($urandom_range(100, 3000), !pl);
        else if (r < 65)
        begin
            if (ir_words.long_limit < 24'd14000000)
                edge_after(ir_words.long_limit + $urandom_range(1, 30000), !pl);
            else
                edge_after($urandom_range(1, 30000), !pl);
        end
        else if (r < 78)
            edge_after($urandom_range(0, (ir_words.merge_limit < 1000) ?
                                         ir_words.merge_limit / 2 + 1 : 400), pl);
        else if (r < 83)
            edge_at(tx_sec + $urandom_range(16, 100), USEC_BITS'($urandom_range(0, 999999)),
                    1'($urandom_range(0, 1)));
        else if (r < 87)
            edge_at(tx_sec - $urandom_range(0, 1), USEC_BITS'($urandom_range(0, 999999)),
                    1'($urandom_range(0, 1)));
        else if (r < 90)
            edge_at($urandom, USEC_BITS'($urandom_range(0, 999999)), 1'($urandom_range(0, 1)));
        else if (r < 92)
            edge_at(tx_sec + $urandom_range(0, 1), USEC_BITS'($urandom_range(1000000, 1048575)),
                    1'($urandom_range(0, 1)));
        else if (r < 96)
            edge_at(tx_sec + $urandom_range(14, 16), USEC_BITS'($urandom_range(0, 999999)),
                    1'($urandom_range(0, 1)));
        else
            edge_after($urandom_range(0, 2000000), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(logic sense, logic [LIMIT_BITS-1:0] merge,
                             logic [LIMIT_BITS-1:0] long_lim, int count, bit choke);
        wait_drained();
        cfg_write(CFG_SPARE, CFG_DATA_BITS'($urandom_range(0, 24'hFF_FFFF)));
        cfg_write(CFG_SENSE_ACTIVE_LOW, CFG_DATA_BITS'(sense));
        cfg_write(CFG_PULSE_MERGE_LIMIT, merge);
        cfg_write(CFG_LONG_SPACE_LIMIT, long_lim);
        if (choke)
            hold_off_req = 1'b1;
        repeat (count)
            random_edge();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        edge_ch.valid     = 1'b0;
        edge_ch.time_sec  = '0;
        edge_ch.time_usec = '0;
        edge_ch.level     = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_SENSE_ACTIVE_LOW;
        cfg_ch.data       = '0;
        tx_sec            = '0;
        tx_usec           = '0;
        burst_left        = 0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a pulse timed from zero, then holds, pulse merging and folding.
        edge_after(500, 1'b1);
        edge_after(900, 1'b0);
        edge_after(30000, 1'b0);
        edge_after(100, 1'b1);
        edge_after(100, 1'b1);
        edge_after(25000, 1'b0);
        edge_after(120, 1'b1);
        edge_after(200, 1'b1);
        edge_after(40000, 1'b0);
        edge_after(500, 1'b0);
        // Clock running backwards, then a long gap that flips the polarity and one that does not.
        edge_at(tx_sec, '0, 1'b1);
        edge_at(tx_sec + 20, USEC_BITS'(5), 1'b1);
        edge_after(100, 1'b0);
        edge_at(tx_sec + 16, USEC_BITS'(7), 1'b1);
        // Microseconds past the end of the second, and an interval that goes negative.
        edge_at(tx_sec, 20'hF_FFFF, 1'b0);
        edge_at(tx_sec + 1, '0, 1'b1);
        edge_at(32'hFFFF_FFFF, USEC_BITS'(999999), 1'b0);
        edge_at(32'hFFFF_FFFF, USEC_BITS'(999999), 1'b1);
        edge_at('0, '0, 1'b0);
        edge_after(300, 1'b0);
        edge_at(tx_sec + 15, tx_usec, 1'b1);
        edge_at(tx_sec + 15, USEC_BITS'(999999), 1'b0);

        run_phase(1'b0, 24'd0, 24'd0, 80, 1'b1);
        run_phase(1'b1, DUR_MAX, DUR_MAX, 80, 1'b0);
        run_phase(1'b0, 24'd300, 24'd5000, 90, 1'b0);
        run_phase(1'b1, LIMIT_BITS'($urandom_range(0, 2000)),
                  LIMIT_BITS'($urandom_range(1000, 60000)), 90, 1'b0);
        run_phase(1'($urandom_range(0, 1)), LIMIT_BITS'($urandom_range(0, 24'hFF_FFFF)),
                  LIMIT_BITS'($urandom_range(0, 24'hFF_FFFF)), 40, 1'b0);
        run_phase(SENSE_RESET, MERGE_LIMIT_RESET, LONG_SPACE_RESET, 70, 1'b0);
        wait_drained();

        if (ir_words.pending_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time,
                     ir_words.pending_words.size());
            ir_words.errors++;
        end
        if (ir_words.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/ipsr_pkg.sv
src/ipsr_if.sv
src/ipsr_front.sv
src/ipsr_fifo.sv
src/ipsr_back.sv
src/ir_pulse_space_recorder_unit.sv
sim/tb_top.sv
